// ----- rtl/core/julia_escape_time_defines.svh -----
// ----------------------------------------------------------------------------
// julia_escape_time_defines.svh
// Assertion macros shared by the escape-time core.
// ----------------------------------------------------------------------------
`ifndef JULIA_ESCAPE_TIME_DEFINES_SVH
`define JULIA_ESCAPE_TIME_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Immediate-implication check, sampled on clk, off during reset.
`define JET_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Next-cycle check: cons must hold in the cycle after ante.
`define JET_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define JET_ASSERT(lbl, prop, msg)
`define JET_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// ----- rtl/core/jet_pkg.sv -----
// ----------------------------------------------------------------------------
// jet_pkg
// Types, constants and the microcode store of the escape-time core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package jet_pkg;

    localparam int Z_W       = 32;
    localparam int FRAC_BITS = 26;
    localparam int CNT_W     = 12;
    localparam int EXP_W     = 4;
    localparam int LIMIT_W   = 13;
    localparam int CFG_IDX_W = 2;
    localparam int PROD_W    = 2 * Z_W;
    localparam int SUM_W     = PROD_W + 1;

    localparam logic [EXP_W-1:0]   EXP_RESET   = 4'd2;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 13'd256;

    // 2.0 in Q13.52
    localparam logic signed [SUM_W-1:0] ESC_LIMIT = 65'sd1 <<< 53;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_C_REAL,
        REG_C_IMAG,
        REG_EXPONENT,
        REG_MAX_ITER
    } cfg_reg_t;

    typedef enum logic [3:0] {
        UP_IDLE,
        UP_M0,
        UP_M1,
        UP_M2,
        UP_M3,
        UP_M4,
        UP_ADDC,
        UP_SQ0,
        UP_SQ1,
        UP_SQ2,
        UP_DONE
    } upc_t;

    typedef enum logic {
        MA_BRE,
        MA_BIM
    } mul_a_t;

    typedef enum logic [1:0] {
        MB_ZRE,
        MB_ZIM,
        MB_BRE,
        MB_BIM
    } mul_b_t;

    typedef enum logic [2:0] {
        WB_NONE,
        WB_ACC,
        WB_TRE,
        WB_POW,
        WB_ADDC,
        WB_ZSAVE
    } wb_t;

    typedef enum logic [2:0] {
        BR_NEXT,
        BR_IDLE,
        BR_MUL,
        BR_TEST,
        BR_DONE
    } br_t;

    typedef struct packed {
        mul_a_t mul_a;
        mul_b_t mul_b;
        wb_t    wb;
        br_t    br;
    } uword_t;

    typedef struct packed {
        uword_t uw;
        logic   load;
    } dp_ctrl_t;

    typedef struct packed {
        logic escape;
    } dp_stat_t;

    // Control store: one word per step.
    function automatic uword_t jet_ucode(input upc_t a);
        uword_t w;
        w = '{mul_a: MA_BRE, mul_b: MB_ZRE, wb: WB_NONE, br: BR_IDLE};
        unique case (a)
            UP_IDLE: w = '{mul_a: MA_BRE, mul_b: MB_ZRE, wb: WB_NONE,  br: BR_IDLE};
            UP_M0:   w = '{mul_a: MA_BRE, mul_b: MB_ZRE, wb: WB_NONE,  br: BR_NEXT};
            UP_M1:   w = '{mul_a: MA_BIM, mul_b: MB_ZIM, wb: WB_ACC,   br: BR_NEXT};
            UP_M2:   w = '{mul_a: MA_BRE, mul_b: MB_ZIM, wb: WB_TRE,   br: BR_NEXT};
            UP_M3:   w = '{mul_a: MA_BIM, mul_b: MB_ZRE, wb: WB_ACC,   br: BR_NEXT};
            UP_M4:   w = '{mul_a: MA_BRE, mul_b: MB_ZRE, wb: WB_POW,   br: BR_MUL};
            UP_ADDC: w = '{mul_a: MA_BRE, mul_b: MB_ZRE, wb: WB_ADDC,  br: BR_NEXT};
            UP_SQ0:  w = '{mul_a: MA_BRE, mul_b: MB_BRE, wb: WB_NONE,  br: BR_NEXT};
            UP_SQ1:  w = '{mul_a: MA_BIM, mul_b: MB_BIM, wb: WB_ACC,   br: BR_NEXT};
            UP_SQ2:  w = '{mul_a: MA_BRE, mul_b: MB_ZRE, wb: WB_ZSAVE, br: BR_TEST};
            UP_DONE: w = '{mul_a: MA_BRE, mul_b: MB_ZRE, wb: WB_NONE,  br: BR_DONE};
            default: w = '{mul_a: MA_BRE, mul_b: MB_ZRE, wb: WB_NONE,  br: BR_IDLE};
        endcase
        return w;
    endfunction

    // Clamp a wide signed value to the Q6.26 range.
    function automatic logic signed [Z_W-1:0] jet_sat(input logic signed [SUM_W-1:0] x);
        logic [SUM_W-Z_W:0] top;
        logic signed [Z_W-1:0] r;
        top = x[SUM_W-1:Z_W-1];
        if ((&top) || !(|top))
            r = x[Z_W-1:0];
        else if (x[SUM_W-1])
            r = {1'b1, {(Z_W-1){1'b0}}};
        else
            r = {1'b0, {(Z_W-1){1'b1}}};
        return r;
    endfunction

endpackage

// ----- rtl/core/jet_channels.sv -----
// ----------------------------------------------------------------------------
// jet_channels
// Valid/ready channel interfaces for points, results and configuration.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface jet_point_if
    import jet_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic signed [Z_W-1:0] z_real;
    logic signed [Z_W-1:0] z_imag;

    modport source (output valid, z_real, z_imag, input ready);
    modport sink   (input valid, z_real, z_imag, output ready);
endinterface

interface jet_result_if
    import jet_pkg::*;
;
    logic             valid;
    logic             ready;
    logic             escaped;
    logic [CNT_W-1:0] escape_count;

    modport source (output valid, escaped, escape_count, input ready);
    modport sink   (input valid, escaped, escape_count, output ready);
endinterface

interface jet_cfg_if
    import jet_pkg::*;
;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [Z_W-1:0]       data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/core/julia_escape_time.sv -----
// ----------------------------------------------------------------------------
// julia_escape_time
// Julia-set escape-time iteration for one Q6.26 start point per transaction.
// ----------------------------------------------------------------------------
// Channels: point (sink) carries z_real/z_imag; result (source) carries
// escaped/escape_count; cfg (sink, always ready) writes c_real, c_imag,
// exponent and max_iterations by index 0..3. Configure only while idle.
// A microcoded sequencer drives one shared 32x32 multiplier. Each iteration
// runs p-1 complex multiplies of four products each, p = exponent clamped
// to MAX_POWER (no multiply when p <= 1), then adds c and takes the two
// squares of the magnitude test. With a limit of 0 no iteration is run.
// One point is in flight at a time; the next point is taken the cycle
// after the result is registered. A result waits in the output register
// while the next point computes; if the receiver still stalls at
// completion, the core holds until it is taken.
// Reset: c = 0, exponent = 2, max_iterations = 256, no result pending.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module julia_escape_time
    import jet_pkg::*;
#(
    parameter int MAX_ITER  = 4096,
    parameter int MAX_POWER = 8
)
(
    input  logic         clk,
    input  logic         rst_n,
    jet_point_if.sink    point,
    jet_result_if.source result,
    jet_cfg_if.sink      cfg
);

    logic signed [Z_W-1:0] c_real_reg, c_real_next;
    logic signed [Z_W-1:0] c_imag_reg, c_imag_next;
    logic [EXP_W-1:0]      exponent_reg, exponent_next;
    logic [LIMIT_W-1:0]    max_iter_reg, max_iter_next;

    dp_ctrl_t ctrl;
    dp_stat_t stat;

    assign cfg.ready = 1'b1;

    always_comb
    begin
        c_real_next   = c_real_reg;
        c_imag_next   = c_imag_reg;
        exponent_next = exponent_reg;
        max_iter_next = max_iter_reg;
        if (cfg.valid)
        begin
            unique case (cfg_reg_t'(cfg.index))
                REG_C_REAL:   c_real_next   = cfg.data;
                REG_C_IMAG:   c_imag_next   = cfg.data;
                REG_EXPONENT: exponent_next = cfg.data[EXP_W-1:0];
                REG_MAX_ITER: max_iter_next = cfg.data[LIMIT_W-1:0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_real_reg   <= '0;
            c_imag_reg   <= '0;
            exponent_reg <= EXP_RESET;
            max_iter_reg <= LIMIT_RESET;
        end
        else
        begin
            c_real_reg   <= c_real_next;
            c_imag_reg   <= c_imag_next;
            exponent_reg <= exponent_next;
            max_iter_reg <= max_iter_next;
        end
    end

    jet_sequencer #(
        .MAX_ITER  (MAX_ITER),
        .MAX_POWER (MAX_POWER)
    ) u_seq (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (point.valid),
        .in_ready       (point.ready),
        .exponent       (exponent_reg),
        .max_iterations (max_iter_reg),
        .stat           (stat),
        .ctrl           (ctrl),
        .out_valid      (result.valid),
        .out_ready      (result.ready),
        .out_escaped    (result.escaped),
        .out_count      (result.escape_count)
    );

    jet_datapath u_dp (
        .clk    (clk),
        .ctrl   (ctrl),
        .z_real (point.z_real),
        .z_imag (point.z_imag),
        .c_real (c_real_reg),
        .c_imag (c_imag_reg),
        .stat   (stat)
    );

endmodule

// ----- rtl/core/jet_datapath.sv -----
// ----------------------------------------------------------------------------
// jet_datapath
// Shared 32x32 multiplier, accumulator and z/power registers driven by
// the control word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module jet_datapath
    import jet_pkg::*;
(
    input  logic                  clk,
    input  dp_ctrl_t              ctrl,
    input  logic signed [Z_W-1:0] z_real,
    input  logic signed [Z_W-1:0] z_imag,
    input  logic signed [Z_W-1:0] c_real,
    input  logic signed [Z_W-1:0] c_imag,
    output dp_stat_t              stat
);

    logic signed [Z_W-1:0]    z_re_reg, z_re_next;
    logic signed [Z_W-1:0]    z_im_reg, z_im_next;
    logic signed [Z_W-1:0]    b_re_reg, b_re_next;
    logic signed [Z_W-1:0]    b_im_reg, b_im_next;
    logic signed [Z_W-1:0]    t_re_reg, t_re_next;
    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic signed [PROD_W-1:0] acc_reg, acc_next;

    logic signed [Z_W-1:0]    op_a;
    logic signed [Z_W-1:0]    op_b;
    logic signed [SUM_W-1:0]  acc_x;
    logic signed [SUM_W-1:0]  prod_x;
    logic signed [SUM_W-1:0]  sum;
    logic signed [SUM_W-1:0]  sum_q;
    logic signed [SUM_W-1:0]  add_re;
    logic signed [SUM_W-1:0]  add_im;

    always_comb
    begin
        op_a = (ctrl.uw.mul_a == MA_BIM) ? b_im_reg : b_re_reg;
        case (ctrl.uw.mul_b)
            MB_ZRE:  op_b = z_re_reg;
            MB_ZIM:  op_b = z_im_reg;
            MB_BRE:  op_b = b_re_reg;
            MB_BIM:  op_b = b_im_reg;
            default: op_b = z_re_reg;
        endcase
        prod_next = op_a * op_b;
    end

    // floor((acc +/- prod) / 2^26); the same adder feeds the escape test
    always_comb
    begin
        acc_x  = {acc_reg[PROD_W-1], acc_reg};
        prod_x = {prod_reg[PROD_W-1], prod_reg};
        sum    = (ctrl.uw.wb == WB_TRE) ? acc_x - prod_x : acc_x + prod_x;
        sum_q  = sum >>> FRAC_BITS;
        add_re = {{(SUM_W-Z_W){b_re_reg[Z_W-1]}}, b_re_reg}
               + {{(SUM_W-Z_W){c_real[Z_W-1]}}, c_real};
        add_im = {{(SUM_W-Z_W){b_im_reg[Z_W-1]}}, b_im_reg}
               + {{(SUM_W-Z_W){c_imag[Z_W-1]}}, c_imag};
        stat.escape = (sum > ESC_LIMIT);
    end

    always_comb
    begin
        z_re_next = z_re_reg;
        z_im_next = z_im_reg;
        b_re_next = b_re_reg;
        b_im_next = b_im_reg;
        t_re_next = t_re_reg;
        acc_next  = acc_reg;
        if (ctrl.load)
        begin
            z_re_next = z_real;
            z_im_next = z_imag;
            b_re_next = z_real;
            b_im_next = z_imag;
        end
        else
        begin
            case (ctrl.uw.wb)
                WB_ACC:   acc_next = prod_reg;
                WB_TRE:   t_re_next = jet_sat(sum_q);
                WB_POW:
                begin
                    b_re_next = t_re_reg;
                    b_im_next = jet_sat(sum_q);
                end
                WB_ADDC:
                begin
                    b_re_next = jet_sat(add_re);
                    b_im_next = jet_sat(add_im);
                end
                WB_ZSAVE:
                begin
                    z_re_next = b_re_reg;
                    z_im_next = b_im_reg;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        z_re_reg <= z_re_next;
        z_im_reg <= z_im_next;
        b_re_reg <= b_re_next;
        b_im_reg <= b_im_next;
        t_re_reg <= t_re_next;
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
    end

endmodule

// ----- rtl/core/jet_sequencer.sv -----
// ----------------------------------------------------------------------------
// jet_sequencer
// Step counter, branch logic, power and iteration counters, result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "julia_escape_time_defines.svh"

module jet_sequencer
    import jet_pkg::*;
#(
    parameter int MAX_ITER  = 4096,
    parameter int MAX_POWER = 8
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [EXP_W-1:0]   exponent,
    input  logic [LIMIT_W-1:0] max_iterations,
    input  dp_stat_t           stat,
    output dp_ctrl_t           ctrl,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               out_escaped,
    output logic [CNT_W-1:0]   out_count
);

    localparam int IT_W = $clog2(MAX_ITER + 1);
    localparam int PW_W = $clog2(MAX_POWER + 1);
    localparam int LC_W = (IT_W > LIMIT_W) ? IT_W : LIMIT_W;
    localparam int PC_W = (PW_W > EXP_W) ? PW_W : EXP_W;

    upc_t             upc_reg, upc_next;
    logic [PW_W-1:0]  kcnt_reg, kcnt_next;
    logic [IT_W-1:0]  iter_reg, iter_next;
    logic             res_esc_reg, res_esc_next;
    logic [CNT_W-1:0] res_cnt_reg, res_cnt_next;
    logic             out_valid_reg, out_valid_next;
    logic             out_esc_reg, out_esc_next;
    logic [CNT_W-1:0] out_cnt_reg, out_cnt_next;

    uword_t           uw;
    logic [LC_W-1:0]  lim_wide;
    logic [PC_W-1:0]  pw_wide;
    logic [IT_W-1:0]  lim;
    logic [PW_W-1:0]  pw;
    logic [PW_W-1:0]  kcnt_inc;
    logic [IT_W:0]    iter_inc;
    upc_t             first_step;
    logic             load;

    always_comb
    begin
        lim_wide = LC_W'(max_iterations);
        pw_wide  = PC_W'(exponent);
        lim = (lim_wide > LC_W'(MAX_ITER)) ? IT_W'(MAX_ITER) : IT_W'(lim_wide);
        pw  = (pw_wide > PC_W'(MAX_POWER)) ? PW_W'(MAX_POWER) : PW_W'(pw_wide);
        kcnt_inc   = kcnt_reg + PW_W'(1);
        iter_inc   = {1'b0, iter_reg} + (IT_W+1)'(1);
        first_step = (pw <= PW_W'(1)) ? UP_ADDC : UP_M0;
    end

    always_comb
    begin
        uw             = jet_ucode(upc_reg);
        upc_next       = upc_reg;
        kcnt_next      = kcnt_reg;
        iter_next      = iter_reg;
        res_esc_next   = res_esc_reg;
        res_cnt_next   = res_cnt_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_esc_next   = out_esc_reg;
        out_cnt_next   = out_cnt_reg;
        in_ready       = 1'b0;
        load           = 1'b0;
        unique case (uw.br)
            BR_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    load      = 1'b1;
                    iter_next = '0;
                    kcnt_next = '0;
                    if (lim == '0)
                    begin
                        res_esc_next = 1'b0;
                        res_cnt_next = '0;
                        upc_next     = UP_DONE;
                    end
                    else
                        upc_next = first_step;
                end
            end
            BR_NEXT:
                upc_next = upc_t'(4'(upc_reg) + 4'd1);
            BR_MUL:
            begin
                kcnt_next = kcnt_inc;
                upc_next  = (kcnt_inc == pw - PW_W'(1)) ? UP_ADDC : UP_M0;
            end
            BR_TEST:
            begin
                if (stat.escape)
                begin
                    res_esc_next = 1'b1;
                    res_cnt_next = CNT_W'(iter_reg);
                    upc_next     = UP_DONE;
                end
                else if (iter_inc == {1'b0, lim})
                begin
                    res_esc_next = 1'b0;
                    res_cnt_next = '0;
                    upc_next     = UP_DONE;
                end
                else
                begin
                    iter_next = iter_inc[IT_W-1:0];
                    kcnt_next = '0;
                    upc_next  = first_step;
                end
            end
            BR_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_esc_next   = res_esc_reg;
                    out_cnt_next   = res_cnt_reg;
                    upc_next       = UP_IDLE;
                end
            end
            default:
                upc_next = UP_IDLE;
        endcase
        ctrl.uw   = uw;
        ctrl.load = load;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg       <= UP_IDLE;
            kcnt_reg      <= '0;
            iter_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            upc_reg       <= upc_next;
            kcnt_reg      <= kcnt_next;
            iter_reg      <= iter_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_esc_reg <= res_esc_next;
        res_cnt_reg <= res_cnt_next;
        out_esc_reg <= out_esc_next;
        out_cnt_reg <= out_cnt_next;
    end

    assign out_valid   = out_valid_reg;
    assign out_escaped = out_esc_reg;
    assign out_count   = out_cnt_reg;

    `JET_ASSERT(a_iter_below_limit, (upc_reg != UP_IDLE && upc_reg != UP_DONE) |-> (iter_reg < lim), "iteration count reached the limit while busy")
    `JET_ASSERT(a_mul_count, (upc_reg == UP_M0) |-> (kcnt_inc < pw), "complex multiply started past the power")
    `JET_ASSERT_NEXT(a_accept_start, in_valid && in_ready, upc_reg == UP_M0 || upc_reg == UP_ADDC || upc_reg == UP_DONE, "bad step after point transaction")
    `JET_ASSERT(a_bounded_count, (out_valid_reg && !out_esc_reg) |-> (out_cnt_reg == '0), "bounded point carries a nonzero count")

endmodule
